### hdl/mbr_pkg.sv
// shared constants, types and helper functions of the block rotation core
package mbr_pkg;

  localparam int LATTICE_WIDTH  = 64;
  localparam int LATTICE_HEIGHT = 64;
  localparam int ID_BITS        = 16;

  localparam int X_BITS     = $clog2(LATTICE_WIDTH);
  localparam int Y_BITS     = $clog2(LATTICE_HEIGHT);
  localparam int BLK_X_BITS = X_BITS - 1;
  localparam int BLK_Y_BITS = Y_BITS - 1;
  localparam int NUM_BANKS  = 4;
  localparam int BANK_AW    = (X_BITS - 1) + (Y_BITS - 1);
  localparam int BANK_DEPTH = (LATTICE_WIDTH / 2) * (LATTICE_HEIGHT / 2);

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_WRITE  = 2'd0;
  localparam opcode_t OP_READ   = 2'd1;
  localparam opcode_t OP_ROTATE = 2'd2;
  localparam opcode_t OP_NOP    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // read request issued on the accept cycle
  typedef struct packed {
    logic              rd_en;
    logic [X_BITS-1:0] x;
    logic [Y_BITS-1:0] y;
  } mbr_issue_t;

  // write-back request on the completing cycle
  typedef struct packed {
    logic               wr_en;
    logic               rotate;
    logic               clockwise;
    logic [X_BITS-1:0]  x;
    logic [Y_BITS-1:0]  y;
    logic [ID_BITS-1:0] wdata;
  } mbr_commit_t;

  // position in the block: 0 origin, 1 above, 2 diagonal, 3 right
  function automatic logic [1:0] role_of_bank(logic [1:0] b, logic x0, logic y0);
    logic dx;
    logic dy;
    dx = b[0] ^ x0;
    dy = b[1] ^ y0;
    return {dx, dx ^ dy};
  endfunction

  function automatic logic [1:0] bank_of_role(logic [1:0] r, logic x0, logic y0);
    logic dx;
    logic dy;
    dx = r[1];
    dy = r[1] ^ r[0];
    return {y0 ^ dy, x0 ^ dx};
  endfunction

  // address inside bank b of the site of that parity next to (x,y)
  function automatic logic [BANK_AW-1:0] bank_addr(logic [1:0] b, logic [X_BITS-1:0] x,
                                                   logic [Y_BITS-1:0] y);
    logic [X_BITS-1:0] xs;
    logic [Y_BITS-1:0] ys;
    xs = (b[0] == x[0]) ? x : x + X_BITS'(1);
    ys = (b[1] == y[0]) ? y : y + Y_BITS'(1);
    return {ys[Y_BITS-1:1], xs[X_BITS-1:1]};
  endfunction

endpackage

### hdl/mbr_cmd_if.sv
// command channel: one word per operation
interface mbr_cmd_if import mbr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [1:0]            opcode;
  logic [5:0]            cell_x;
  logic [5:0]            cell_y;
  logic [15:0]           cell_value;
  logic [4:0]            block_col;
  logic [4:0]            block_row;
  logic                  rotate_clockwise;
  logic                  sweep_end;

  modport source (output valid, opcode, cell_x, cell_y, cell_value, block_col, block_row,
                  rotate_clockwise, sweep_end, input ready);
  modport sink (input valid, opcode, cell_x, cell_y, cell_value, block_col, block_row,
                rotate_clockwise, sweep_end, output ready);
endinterface

### hdl/mbr_rsp_if.sv
// response channel: one word per operation
interface mbr_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;
  logic        read_valid;

  modport source (output valid, read_value, read_valid, input ready);
  modport sink (input valid, read_value, read_valid, output ready);
endinterface

### hdl/mbr_ram.sv
// generic simple dual-port ram with registered read
module mbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/mbr_lattice.sv
// lattice store in four parity banks with quarter-turn write-back
module mbr_lattice import mbr_pkg::*; (
  input  logic               clk,
  input  mbr_issue_t         issue,
  input  mbr_commit_t        commit,
  output logic [ID_BITS-1:0] read_data
);

  logic [ID_BITS-1:0] rd_data [NUM_BANKS];

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [1:0]         role;
    logic [1:0]         src_role;
    logic [1:0]         src_bank;
    logic               own_site;
    logic               we;
    logic [ID_BITS-1:0] wd;

    always_comb begin
      role     = role_of_bank(2'(b), commit.x[0], commit.y[0]);
      src_role = commit.clockwise ? role - 2'd1 : role + 2'd1;
      src_bank = bank_of_role(src_role, commit.x[0], commit.y[0]);
      own_site = (2'(b) == {commit.y[0], commit.x[0]});
      we       = commit.wr_en && (commit.rotate || own_site);
      wd       = commit.rotate ? rd_data[src_bank] : commit.wdata;
    end

    mbr_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (we),
      .wr_addr (bank_addr(2'(b), commit.x, commit.y)),
      .wr_data (wd),
      .rd_en   (issue.rd_en),
      .rd_addr (bank_addr(2'(b), issue.x, issue.y)),
      .rd_data (rd_data[b])
    );
  end

  // bank holding the addressed cell of a read
  assign read_data = rd_data[{commit.y[0], commit.x[0]}];

endmodule

### hdl/margolus_block_rotation_core.sv
// top level of the margolus block rotation core
//
//   channel  dir  word contents
//   cmd      in   opcode, cell_x, cell_y, cell_value, block_col, block_row,
//                 rotate_clockwise, sweep_end
//   rsp      out  read_value, read_valid (one word per command word)
//
// each command word is accepted in ST_IDLE, whose accept cycle reads all four parity
// banks at once for a read or rotate; ST_EXEC writes the banks back for a write or
// rotate and loads the response register; no new word is accepted before that write-back
// the response register lets a word be accepted while the last response waits;
// if it is still held at write-back time, write-back stalls until it is taken
// rst (synchronous) clears the phase and control state; lattice contents stay
// undefined until written, so no clearing pass is run
module margolus_block_rotation_core import mbr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mbr_cmd_if.sink   cmd,
  mbr_rsp_if.source rsp
);

  state_t             state;
  state_t             state_next;
  logic               phase;

  // captured command word
  opcode_t            op;
  logic [X_BITS-1:0]  x;
  logic [Y_BITS-1:0]  y;
  logic [ID_BITS-1:0] value;
  logic               clockwise;
  logic               sweep;

  logic               accept;
  logic               done;
  logic [X_BITS-1:0]  x_next;
  logic [Y_BITS-1:0]  y_next;
  logic [ID_BITS-1:0] read_data;
  mbr_issue_t         issue;
  mbr_commit_t        commit;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  // write-back only once the response register is free or draining
  assign done      = (state == ST_EXEC) && (!rsp.valid || rsp.ready);

  // block origin shifts one site diagonally in the shifted partition
  always_comb begin
    if (cmd.opcode == OP_ROTATE) begin
      x_next = {cmd.block_col, 1'b0} + X_BITS'(phase);
      y_next = {cmd.block_row, 1'b0} + Y_BITS'(phase);
    end else begin
      x_next = cmd.cell_x;
      y_next = cmd.cell_y;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      // sweep end swaps the partition after the rotation
      if (done && op == OP_ROTATE && sweep) begin
        phase <= ~phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= cmd.opcode;
      x         <= x_next;
      y         <= y_next;
      value     <= cmd.cell_value;
      clockwise <= cmd.rotate_clockwise;
      sweep     <= cmd.sweep_end;
    end
  end

  // bank reads go out straight from the command word on the accept cycle
  always_comb begin
    issue.rd_en = accept && (cmd.opcode == OP_READ || cmd.opcode == OP_ROTATE);
    issue.x     = x_next;
    issue.y     = y_next;
  end

  always_comb begin
    commit.wr_en     = done && (op == OP_WRITE || op == OP_ROTATE);
    commit.rotate    = (op == OP_ROTATE);
    commit.clockwise = clockwise;
    commit.x         = x;
    commit.y         = y;
    commit.wdata     = value;
  end

  mbr_lattice u_lattice (
    .clk       (clk),
    .issue     (issue),
    .commit    (commit),
    .read_data (read_data)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp.read_valid <= (op == OP_READ);
      rsp.read_value <= (op == OP_READ) ? read_data : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("second word accepted before write-back");

  a_zero_when_not_read: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.read_valid) |-> (rsp.read_value == '0))
    else $error("non-read response carries data");

  a_phase_toggle: assert property (@(posedge clk) disable iff (rst)
    (phase != $past(phase)) |-> $past(done && op == OP_ROTATE && sweep))
    else $error("phase changed without a sweep-end rotate");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == ST_EXEC))
    else $error("response raised outside write-back");
`endif

endmodule

### dv/mbr_checker.sv
// checker of the block rotation core: lattice predictor and response comparison
module mbr_checker import mbr_pkg::*; (
  input  logic clk,
  input  logic rst,
  mbr_cmd_if   cmd,
  mbr_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] read_value;
    logic        read_valid;
  } answer_t;

  // predicted lattice contents, indexed [y][x]
  logic [ID_BITS-1:0] cells [LATTICE_HEIGHT][LATTICE_WIDTH];
  logic               phase_shifted;
  answer_t            due_answers[$];
  int                 mismatches = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // applies one command word to the predicted lattice, gives its response word
  task automatic apply_command(input opcode_t op, input logic [X_BITS-1:0] x,
                               input logic [Y_BITS-1:0] y, input logic [15:0] v,
                               input logic [BLK_X_BITS-1:0] bc,
                               input logic [BLK_Y_BITS-1:0] br,
                               input logic cw, input logic se, output answer_t ans);
    logic [X_BITS-1:0]  ox;
    logic [X_BITS-1:0]  x1;
    logic [Y_BITS-1:0]  oy;
    logic [Y_BITS-1:0]  y1;
    logic [ID_BITS-1:0] v0;
    logic [ID_BITS-1:0] v1;
    logic [ID_BITS-1:0] v2;
    logic [ID_BITS-1:0] v3;
    ans = '0;
    case (op)
      OP_WRITE: begin
        cells[y][x] = v[ID_BITS-1:0];
      end
      OP_READ: begin
        ans.read_value = 16'(cells[y][x]);
        ans.read_valid = 1'b1;
      end
      OP_ROTATE: begin
        ox = {bc, 1'b0} + X_BITS'(phase_shifted);
        oy = {br, 1'b0} + Y_BITS'(phase_shifted);
        x1 = ox + X_BITS'(1);
        y1 = oy + Y_BITS'(1);
        v0 = cells[oy][ox];
        v1 = cells[y1][ox];
        v2 = cells[y1][x1];
        v3 = cells[oy][x1];
        if (cw) begin
          cells[y1][ox] = v0;
          cells[y1][x1] = v1;
          cells[oy][x1] = v2;
          cells[oy][ox] = v3;
        end else begin
          cells[oy][x1] = v0;
          cells[oy][ox] = v1;
          cells[y1][ox] = v2;
          cells[y1][x1] = v3;
        end
        if (se) phase_shifted = ~phase_shifted;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    answer_t ans;
    answer_t due;
    if (rst) begin
      phase_shifted = 1'b0;
      due_answers.delete();
    end else begin
      // responses first: a word accepted now cannot answer in the same cycle
      if (rsp.valid && rsp.ready) begin
        if (due_answers.size() == 0) begin
          report("response word with none due", 32'(rsp.read_value), 32'd0);
        end else begin
          due = due_answers.pop_front();
          if (rsp.read_value !== due.read_value) report("read_value", 32'(rsp.read_value),
                                                        32'(due.read_value));
          if (rsp.read_valid !== due.read_valid) report("read_valid", 32'(rsp.read_valid),
                                                        32'(due.read_valid));
        end
      end
      if (cmd.valid && cmd.ready) begin
        apply_command(opcode_t'(cmd.opcode), cmd.cell_x, cmd.cell_y, cmd.cell_value,
                      cmd.block_col, cmd.block_row, cmd.rotate_clockwise, cmd.sweep_end,
                      ans);
        due_answers = {due_answers, ans};
      end
    end
    pending    <= due_answers.size();
    fail_count <= mismatches;
  end

endmodule

### dv/tb_top.sv
// testbench top of the block rotation core: stimulus, back-pressure and verdict
module tb_top import mbr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 1350;
  localparam int HOLD_AT     = 400;     // long receiver hold-off starts here
  localparam int PAUSE_AT    = 800;     // sender waits for a full drain here
  localparam int CALM_AT     = 1200;    // no idling on either side from here
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst;

  mbr_cmd_if cmd_ch ();
  mbr_rsp_if rsp_ch ();

  int fail_count;
  int pending;
  int cycle_count;
  int items_sent = 0;

  // stimulus-side bookkeeping: which sites hold a written value, and the phase,
  // so that no read or rotate ever touches an unwritten site
  bit written [LATTICE_HEIGHT][LATTICE_WIDTH];
  bit stim_phase = 1'b0;

  // handshakes between stimulus and receiver processes
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  bit calm      = 1'b0;
  bit paused    = 1'b0;

  always #4 clk = ~clk;

  margolus_block_rotation_core i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  mbr_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog: a run that never drains ends here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // receiver: random ready bursts, one long hold-off on request, steady in the tail
  initial begin
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        // long stall counted here so the core fills up and stops taking words
        rsp_ch.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // offers one command word and waits for it to be taken; an idle burst may follow
  task automatic send_word(input opcode_t op, input logic [X_BITS-1:0] x,
                           input logic [Y_BITS-1:0] y, input logic [15:0] v,
                           input logic [BLK_X_BITS-1:0] bc, input logic [BLK_Y_BITS-1:0] br,
                           input logic cw, input logic se);
    cmd_ch.valid            <= 1'b1;
    cmd_ch.opcode           <= op;
    cmd_ch.cell_x           <= x;
    cmd_ch.cell_y           <= y;
    cmd_ch.cell_value       <= v;
    cmd_ch.block_col        <= bc;
    cmd_ch.block_row        <= br;
    cmd_ch.rotate_clockwise <= cw;
    cmd_ch.sweep_end        <= se;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
    if (op == OP_WRITE) written[y][x] = 1'b1;
    if (op == OP_ROTATE && se) stim_phase = ~stim_phase;
    // sender idle burst
    if (!calm && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic write_cell(input logic [X_BITS-1:0] x, input logic [Y_BITS-1:0] y);
    send_word(OP_WRITE, x, y, 16'($urandom), BLK_X_BITS'($urandom), BLK_Y_BITS'($urandom),
              1'($urandom), 1'($urandom));
  endtask

  // reads a site, writing it first if it never held a value
  task automatic read_cell(input logic [X_BITS-1:0] x, input logic [Y_BITS-1:0] y);
    if (!written[y][x]) write_cell(x, y);
    send_word(OP_READ, x, y, 16'($urandom), BLK_X_BITS'($urandom), BLK_Y_BITS'($urandom),
              1'($urandom), 1'($urandom));
  endtask

  // rotates a block, filling any of its four sites still unwritten beforehand
  task automatic rotate_block(input logic [BLK_X_BITS-1:0] bc,
                              input logic [BLK_Y_BITS-1:0] br, input logic cw,
                              input logic se);
    logic [X_BITS-1:0] ox;
    logic [Y_BITS-1:0] oy;
    ox = {bc, 1'b0} + X_BITS'(stim_phase);
    oy = {br, 1'b0} + Y_BITS'(stim_phase);
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        if (!written[oy + Y_BITS'(dy)][ox + X_BITS'(dx)])
          write_cell(ox + X_BITS'(dx), oy + Y_BITS'(dy));
      end
    end
    send_word(OP_ROTATE, X_BITS'($urandom), Y_BITS'($urandom), 16'($urandom), bc, br, cw, se);
  endtask

  // sender stops and waits until every response word has come back
  task automatic drain_wait();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // coordinates mostly from a small window across the wrap, so blocks overlap often
  function automatic logic [X_BITS-1:0] pick_coord();
    if ($urandom_range(0, 3) != 0) return X_BITS'($urandom_range(60, 67));
    return X_BITS'($urandom);
  endfunction

  function automatic logic [BLK_X_BITS-1:0] pick_block();
    if ($urandom_range(0, 3) != 0) return BLK_X_BITS'($urandom_range(30, 33));
    return BLK_X_BITS'($urandom);
  endfunction

  initial begin
    int pick;
    rst                     <= 1'b1;
    cmd_ch.valid            <= 1'b0;
    cmd_ch.opcode           <= OP_NOP;
    cmd_ch.cell_x           <= '0;
    cmd_ch.cell_y           <= '0;
    cmd_ch.cell_value       <= '0;
    cmd_ch.block_col        <= '0;
    cmd_ch.block_row        <= '0;
    cmd_ch.rotate_clockwise <= 1'b0;
    cmd_ch.sweep_end        <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme values and corners, sweep-end mark ignored on write and read
    send_word(OP_WRITE, 6'd0, 6'd0, 16'hFFFF, 5'd31, 5'd31, 1'b1, 1'b1);
    send_word(OP_WRITE, 6'd63, 6'd63, 16'h0000, 5'd0, 5'd0, 1'b0, 1'b0);
    send_word(OP_READ, 6'd0, 6'd0, 16'h0000, 5'd0, 5'd0, 1'b0, 1'b1);
    send_word(OP_READ, 6'd63, 6'd63, 16'hFFFF, 5'd31, 5'd31, 1'b1, 1'b0);
    // no-operation words with all-ones and all-zero fields
    send_word(OP_NOP, 6'd63, 6'd63, 16'hFFFF, 5'd31, 5'd31, 1'b1, 1'b1);
    send_word(OP_NOP, 6'd0, 6'd0, 16'h0000, 5'd0, 5'd0, 1'b0, 1'b0);
    // both directions on the normal partition, then toggle to the shifted one
    rotate_block(5'd0, 5'd0, 1'b1, 1'b0);
    read_cell(6'd0, 6'd0);
    read_cell(6'd0, 6'd1);
    read_cell(6'd1, 6'd1);
    read_cell(6'd1, 6'd0);
    rotate_block(5'd0, 5'd0, 1'b0, 1'b1);
    // shifted block at the far corner wraps on both axes
    rotate_block(5'd31, 5'd31, 1'b1, 1'b0);
    read_cell(6'd0, 6'd63);
    read_cell(6'd63, 6'd0);
    rotate_block(5'd31, 5'd31, 1'b0, 1'b1);
    read_cell(6'd63, 6'd63);

    // random part
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= HOLD_AT && !hold_req) hold_req = 1'b1;
      if (items_sent >= PAUSE_AT && !calm && !paused) begin
        drain_wait();
        paused = 1'b1;
      end
      if (items_sent >= CALM_AT) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // one sweep over the window's blocks, phase toggled on the last one
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            rotate_block(BLK_X_BITS'(30 + c), BLK_Y_BITS'(30 + r), 1'($urandom),
                         (r == 3 && c == 3));
          end
        end
      end else if (pick < 40) begin
        rotate_block(pick_block(), pick_block(), 1'($urandom), $urandom_range(0, 7) == 0);
      end else if (pick < 65) begin
        read_cell(pick_coord(), pick_coord());
      end else if (pick < 90) begin
        write_cell(pick_coord(), pick_coord());
      end else begin
        send_word(OP_NOP, X_BITS'($urandom), Y_BITS'($urandom), 16'($urandom),
                  BLK_X_BITS'($urandom), BLK_Y_BITS'($urandom), 1'($urandom), 1'($urandom));
      end
    end

    // all words sent: wait for the last responses, then a quiet tail
    drain_wait();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hdl/mbr_pkg.sv
hdl/mbr_cmd_if.sv
hdl/mbr_rsp_if.sv
hdl/mbr_ram.sv
hdl/mbr_lattice.sv
hdl/margolus_block_rotation_core.sv
dv/mbr_checker.sv
dv/tb_top.sv
